FILE: rtl/sile_pkg.sv
// shared types and codes for the sorted item list engine
`default_nettype none
package sile_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [1:0] {
        CMD_SORTED = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_IN_LIST  = 2'd1,
        ST_NOT_LIST = 2'd2,
        ST_RSVD     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_WALK_RD,
        S_WALK_CHK,
        S_WALK_CMP,
        S_LINK_RD,
        S_LINK_WR,
        S_LINK_OWN,
        S_UNLINK_RD,
        S_UNLINK_WR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_HEAD_KEY,
        S_OUT
    } fsm_t;

endpackage : sile_pkg
`default_nettype wire

FILE: rtl/sile_if.sv
// valid/ready channel interface with payload
`default_nettype none
interface sile_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface : sile_if
`default_nettype wire

FILE: rtl/sile_ram.sv
// generic single port ram with registered read
`default_nettype none
module sile_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule : sile_ram
`default_nettype wire

FILE: rtl/sorted_item_list_engine_core.sv
// sorted doubly linked list engine: top level
//
// channel  | dir | fields
// ---------+-----+------------------------------------------------------
// cmd_in   | in  | command, item_id, list_sel, sort_value
// rsp_out  | out | status, list_id, item_count, head_valid, head_item,
//          |     | head_value
//
// one command at a time; from idle a command passes lookup, then the walk for a
// sorted insert, the link states for an insert or append, or the unlink states
// for a remove (nop and errors go straight on), then the head read and the
// result beat
// the walk reads node_next then item_value each step, on separate memories
// node links are set to point at their own node by a sweep over all nodes after
// reset; no command beat is taken during that sweep
// a result stays on rsp_out until taken; the next command waits for it
`default_nettype none
module sorted_item_list_engine_core
    import sile_pkg::*;
#(
    parameter int unsigned ITEM_SLOTS = 32,
    parameter int unsigned LIST_COUNT = 4,
    parameter int unsigned KEY_BITS   = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    sile_if.sink     cmd_in,
    sile_if.source   rsp_out
);
    localparam int unsigned NODES  = ITEM_SLOTS + LIST_COUNT;
    localparam int unsigned NODE_W = $clog2(NODES);
    localparam int unsigned LIST_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int unsigned ITEM_W = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
    localparam int unsigned CNT_W  = $clog2(ITEM_SLOTS + 1);

    // memories: next and prev links per node, key per item
    logic              nx_we, pv_we, kv_we;
    logic [NODE_W-1:0] nx_addr, pv_addr;
    logic [NODE_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [ITEM_W-1:0] kv_addr;
    logic [KEY_BITS-1:0] kv_wdata, kv_rdata;

    sile_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_next (
        .clk(clk), .we(nx_we), .addr(nx_addr), .wdata(nx_wdata), .rdata(nx_rdata));
    sile_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_prev (
        .clk(clk), .we(pv_we), .addr(pv_addr), .wdata(pv_wdata), .rdata(pv_rdata));
    sile_ram #(.WIDTH(KEY_BITS), .DEPTH(ITEM_SLOTS)) u_key (
        .clk(clk), .we(kv_we), .addr(kv_addr), .wdata(kv_wdata), .rdata(kv_rdata));

    // small per-list and per-item state in flops
    logic [LIST_W:0]     home_reg [ITEM_SLOTS];  // 0 free, else list+1
    logic [CNT_W-1:0]    count_reg [LIST_COUNT];
    logic [NODE_W-1:0]   cursor_reg [LIST_COUNT];

    fsm_t state_reg, state_next;
    logic [NODE_W-1:0] sweep_reg;
    logic              swept_reg;

    // latched command
    cmd_t              cmd_reg;
    logic [ITEM_W-1:0] item_reg;
    logic              item_ok_reg;
    logic [LIST_W-1:0] list_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [NODE_W-1:0] at_reg, nx_reg;
    logic [CNT_W-1:0]  steps_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [NODE_W-1:0] head_reg;

    // item's own next link, written in the cycle after the neighbors
    logic [NODE_W-1:0] own_next_reg;

    // result register
    logic [1:0]  r_status_reg, r_list_reg;
    logic [5:0]  r_count_reg;
    logic        r_hv_reg;
    logic [4:0]  r_item_reg;
    logic [31:0] r_value_reg;

    logic [4:0]  in_item;
    logic [1:0]  in_list;
    logic [31:0] in_key;
    assign in_item = cmd_in.data.item_id;
    assign in_list = cmd_in.data.list_sel;
    assign in_key  = cmd_in.data.sort_value;

    function automatic logic [NODE_W-1:0] sent_of(input logic [LIST_W-1:0] l);
        sent_of = NODE_W'(ITEM_SLOTS) + NODE_W'(l);
    endfunction

    assign cmd_in.ready  = (state_reg == S_IDLE) && swept_reg;
    assign rsp_out.valid = (state_reg == S_OUT);
    assign rsp_out.data.status     = r_status_reg;
    assign rsp_out.data.list_id    = r_list_reg;
    assign rsp_out.data.item_count = r_count_reg;
    assign rsp_out.data.head_valid = r_hv_reg;
    assign rsp_out.data.head_item  = r_item_reg;
    assign rsp_out.data.head_value = r_value_reg;

    logic [LIST_W-1:0] home_list;
    logic              home_busy;
    assign home_busy = (home_reg[item_reg] != '0);
    assign home_list = LIST_W'(home_reg[item_reg] - 1'b1);

    logic walk_stop;
    logic key_stop;
    // stop when the next node is a sentinel or the step count reaches ITEM_SLOTS
    assign walk_stop = (nx_rdata >= NODE_W'(ITEM_SLOTS))
                       || (steps_reg >= CNT_W'(ITEM_SLOTS));
    // stop when the next node's key exceeds the new key
    assign key_stop = (kv_rdata > key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (cmd_in.valid && cmd_in.ready) state_next = S_LOOKUP;
            S_LOOKUP:
            begin
                priority if (cmd_reg == CMD_NOP || !item_ok_reg) state_next = S_HEAD_RD;
                else if (cmd_reg == CMD_REMOVE)
                    state_next = home_busy ? S_UNLINK_RD : S_HEAD_RD;
                else if (home_busy) state_next = S_HEAD_RD;
                else if (cmd_reg == CMD_SORTED) state_next = S_WALK_RD;
                else state_next = S_LINK_RD;
            end
            S_WALK_RD:   state_next = S_WALK_CHK;
            S_WALK_CHK:  state_next = walk_stop ? S_LINK_RD : S_WALK_CMP;
            S_WALK_CMP:  state_next = key_stop ? S_LINK_RD : S_WALK_CHK;
            S_LINK_RD:   state_next = S_LINK_WR;
            S_LINK_WR:   state_next = S_LINK_OWN;
            S_LINK_OWN:  state_next = S_HEAD_RD;
            S_UNLINK_RD: state_next = S_UNLINK_WR;
            S_UNLINK_WR: state_next = S_HEAD_RD;
            S_HEAD_RD:   state_next = S_HEAD_WAIT;
            S_HEAD_WAIT: state_next = S_HEAD_KEY;
            S_HEAD_KEY:  state_next = S_OUT;
            S_OUT:       if (rsp_out.ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        nx_we = 1'b0; pv_we = 1'b0; kv_we = 1'b0;
        nx_addr = at_reg; pv_addr = at_reg;
        nx_wdata = '0; pv_wdata = '0;
        kv_addr = item_reg; kv_wdata = key_reg;
        if (!swept_reg)
        begin
            nx_we = 1'b1; pv_we = 1'b1;
            nx_addr = sweep_reg; pv_addr = sweep_reg;
            nx_wdata = sweep_reg; pv_wdata = sweep_reg;
        end
        else
        begin
            unique case (state_reg)
                S_LOOKUP:
                begin
                    // start at the sentinel for a walk, prev of cursor for append
                    nx_addr = sent_of(list_reg);
                    pv_addr = cursor_reg[list_reg];
                    kv_we = item_ok_reg && !home_busy &&
                            (cmd_reg == CMD_SORTED || cmd_reg == CMD_APPEND);
                end
                S_WALK_RD:
                begin
                    nx_addr = at_reg;
                end
                S_WALK_CHK:
                begin
                    kv_addr = ITEM_W'(nx_rdata);
                    nx_addr = at_reg;
                end
                S_WALK_CMP:
                begin
                    // fetch the link after the candidate in case the walk goes on
                    nx_addr = nx_reg;
                end
                S_LINK_RD:
                begin
                    nx_addr = (cmd_reg == CMD_APPEND) ? pv_rdata : at_reg;
                end
                S_LINK_WR:
                begin
                    // at.next = item, nx.prev = item
                    nx_we = 1'b1; nx_addr = at_reg; nx_wdata = NODE_W'(item_reg);
                    pv_we = 1'b1; pv_addr = nx_rdata; pv_wdata = NODE_W'(item_reg);
                end
                S_LINK_OWN:
                begin
                    // item.next = old at.next, item.prev = at
                    nx_we = 1'b1; nx_addr = NODE_W'(item_reg); nx_wdata = own_next_reg;
                    pv_we = 1'b1; pv_addr = NODE_W'(item_reg); pv_wdata = at_reg;
                end
                S_UNLINK_RD:
                begin
                    nx_addr = NODE_W'(item_reg);
                    pv_addr = NODE_W'(item_reg);
                end
                S_UNLINK_WR:
                begin
                    nx_we = 1'b1; nx_addr = pv_rdata; nx_wdata = nx_rdata;
                    pv_we = 1'b1; pv_addr = nx_rdata; pv_wdata = pv_rdata;
                end
                S_HEAD_RD:
                begin
                    nx_addr = sent_of(list_reg);
                end
                S_HEAD_WAIT:
                begin
                    kv_addr = ITEM_W'(nx_rdata);
                end
                default:
                begin
                    nx_addr = at_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sweep_reg <= '0;
            swept_reg <= 1'b0;
            for (int i = 0; i < ITEM_SLOTS; i++) home_reg[i] <= '0;
            for (int l = 0; l < LIST_COUNT; l++)
            begin
                count_reg[l]  <= '0;
                cursor_reg[l] <= NODE_W'(ITEM_SLOTS + l);
            end
        end
        else
        begin
            if (!swept_reg)
            begin
                sweep_reg <= sweep_reg + 1'b1;
                if (sweep_reg == NODE_W'(NODES - 1)) swept_reg <= 1'b1;
            end
            state_reg <= state_next;
            if (state_reg == S_LINK_WR)
            begin
                home_reg[item_reg]  <= (LIST_W+1)'(list_reg) + 1'b1;
                count_reg[list_reg] <= count_reg[list_reg] + 1'b1;
            end
            if (state_reg == S_UNLINK_WR)
            begin
                home_reg[item_reg] <= '0;
                if (cursor_reg[list_reg] == NODE_W'(item_reg))
                    cursor_reg[list_reg] <= pv_rdata;
                if (count_reg[list_reg] != '0)
                    count_reg[list_reg] <= count_reg[list_reg] - 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_in.valid && cmd_in.ready)
        begin
            cmd_reg     <= cmd_t'(cmd_in.data.command);
            item_reg    <= ITEM_W'(in_item);
            item_ok_reg <= (32'(in_item) < ITEM_SLOTS);
            list_reg    <= LIST_W'(32'(in_list) % LIST_COUNT);
            key_reg     <= KEY_BITS'(in_key);
            steps_reg   <= '0;
            st_reg      <= ST_OK;
        end
        unique case (state_reg)
            S_LOOKUP:
            begin
                at_reg <= sent_of(list_reg);
                priority if (cmd_reg == CMD_NOP) st_reg <= ST_OK;
                else if (!item_ok_reg) st_reg <= ST_NOT_LIST;
                else if (cmd_reg == CMD_REMOVE)
                begin
                    st_reg <= home_busy ? ST_OK : ST_NOT_LIST;
                    if (home_busy) list_reg <= home_list;
                end
                else st_reg <= home_busy ? ST_IN_LIST : ST_OK;
            end
            S_WALK_CHK:
            begin
                nx_reg <= nx_rdata;
            end
            S_WALK_CMP:
            begin
                // candidate key not larger: step past it
                if (!key_stop)
                begin
                    at_reg    <= nx_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
            end
            S_LINK_RD:
            begin
                if (cmd_reg == CMD_APPEND) at_reg <= pv_rdata;
            end
            S_LINK_WR:
            begin
                own_next_reg <= nx_rdata;
            end
            S_HEAD_WAIT:
            begin
                head_reg <= nx_rdata;
                r_hv_reg <= (count_reg[list_reg] != '0) && (nx_rdata < NODE_W'(ITEM_SLOTS));
            end
            S_HEAD_KEY:
            begin
                // head key arrives from the key memory this cycle
                r_status_reg <= st_reg;
                r_list_reg   <= 2'(list_reg);
                r_count_reg  <= 6'(count_reg[list_reg]);
                r_item_reg   <= r_hv_reg ? 5'(head_reg) : 5'd0;
                r_value_reg  <= r_hv_reg ? 32'(kv_rdata) : 32'd0;
            end
            default:
            begin
                nx_reg <= nx_reg;
            end
        endcase
        if (state_reg == S_OUT && rsp_out.ready) steps_reg <= '0;
    end

endmodule : sorted_item_list_engine_core
`default_nettype wire

FILE: rtl/sile_checker.sv
// port level checks for the list engine, bound to the top level
`default_nettype none
module sile_checker
    import sile_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] status,
    input wire logic [5:0] item_count,
    input wire logic head_valid
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("command taken while result pending");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second command taken too early");
    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (head_valid == (item_count != 6'd0)))
        else $error("head flag disagrees with count");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != ST_RSVD) else $error("reserved status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule : sile_checker

bind sorted_item_list_engine_core sile_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
    .out_valid(rsp_out.valid), .out_ready(rsp_out.ready),
    .status(rsp_out.data.status), .item_count(rsp_out.data.item_count),
    .head_valid(rsp_out.data.head_valid)
);
`default_nettype wire
